>>> design/dws_pkg.sv
// ----------------------------------------------------------------------------
// dws_pkg
// Shared codes, types and defaults for the searchable double-ended queue.
// ----------------------------------------------------------------------------
package dws_pkg;

  // default number of ring entries
  localparam int DEPTH_DEF = 16;

  // word widths
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;

  // request opcodes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;
  localparam logic [OP_W-1:0] OP_LIST       = 3'd5;

  // response status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LIST,
    S_REPLY
  } state_t;

endpackage

>>> design/dws_ram.sv
// ----------------------------------------------------------------------------
// dws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/deque_with_search_top.sv
// ----------------------------------------------------------------------------
// deque_with_search_top
// Bounded double-ended queue of signed 32-bit words held in a RAM ring,
// with push/pop at both ends, key search and a front-to-back list walk.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_ready) carries opcode and value; req_ready
// is high only while the sequencer is idle. Opcodes 6 and 7 are taken and
// dropped. Response channel (rsp_valid/rsp_ready) carries status, element,
// found and last: one word per other request, or one per held element for a list
// of a non-empty queue, front first, last set on the back element.
// Push and pop answer through the reply state. A search reads one entry per
// cycle from the RAM and answers through the reply state once every held
// entry is compared. A list gives one word per cycle while the output is
// not stalled. A word waits in the output register while rsp_ready is
// low and the walk stalls with it; the next request is taken once the last
// word is in the output register. Reset empties the queue and clears
// rsp_valid; RAM contents are not cleared, and a word not yet written is
// never used.
// ----------------------------------------------------------------------------
module deque_with_search_top
  import dws_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  logic [OP_W-1:0]          opcode,
  input  logic signed [DATA_W-1:0] value,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output logic [STAT_W-1:0]        status,
  output logic signed [DATA_W-1:0] element,
  output logic                     found,
  output logic                     last
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  // control state
  state_t state, state_next;
  logic [IDX_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] rd_pos, rd_pos_next;
  logic [CNT_W-1:0] rem, rem_next;
  logic             hit, hit_next;

  // pending single-word reply and search key
  logic [DATA_W-1:0] key, key_next;
  logic [STAT_W-1:0] res_status, res_status_next;
  logic              res_found, res_found_next;
  logic              res_data, res_data_next;

  // ram ports
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] rdata;

  logic accept, slot_free, empty, full;
  logic [IDX_W-1:0] head_inc, head_dec, back_slot, back_last, pos_inc;
  logic [SUM_W-1:0] sum_slot, sum_last;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign slot_free = !rsp_valid || rsp_ready;
  assign empty     = (count == '0);
  assign full      = (count == CNT_W'(DEPTH));

  // ring index arithmetic
  assign head_inc = (head == IDX_W'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? IDX_W'(DEPTH - 1) : head - 1'b1;
  assign pos_inc  = (rd_pos == IDX_W'(DEPTH - 1)) ? '0 : rd_pos + 1'b1;
  assign sum_slot = SUM_W'(head) + SUM_W'(count);
  assign sum_last = sum_slot - 1'b1;
  assign back_slot = (sum_slot >= SUM_W'(DEPTH)) ? IDX_W'(sum_slot - SUM_W'(DEPTH))
                                                 : IDX_W'(sum_slot);
  assign back_last = (sum_last >= SUM_W'(DEPTH)) ? IDX_W'(sum_last - SUM_W'(DEPTH))
                                                 : IDX_W'(sum_last);

  // entry store
  dws_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(value),
    .raddr(rd_pos_next),
    .rdata(rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_POP_FRONT, OP_POP_BACK: begin
              state_next = S_REPLY;
            end
            OP_SEARCH: begin
              state_next = empty ? S_REPLY : S_SCAN;
            end
            OP_LIST: begin
              state_next = empty ? S_REPLY : S_LIST;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rem == CNT_W'(1)) state_next = S_REPLY;
      end
      S_LIST: begin
        if (slot_free && rem == CNT_W'(1)) state_next = S_IDLE;
      end
      S_REPLY: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // datapath and ram control
  always_comb begin
    head_next       = head;
    count_next      = count;
    rd_pos_next     = rd_pos;
    rem_next        = rem;
    hit_next        = hit;
    key_next        = key;
    res_status_next = res_status;
    res_found_next  = res_found;
    res_data_next   = res_data;
    we              = 1'b0;
    waddr           = back_slot;
    case (state)
      S_IDLE: begin
        if (accept) begin
          res_found_next = 1'b0;
          res_data_next  = 1'b0;
          case (opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (full) begin
                res_status_next = ST_FULL;
              end else begin
                res_status_next = ST_OK;
                we              = 1'b1;
                count_next      = count + 1'b1;
                if (opcode == OP_PUSH_FRONT) begin
                  head_next = head_dec;
                  waddr     = head_dec;
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (empty) begin
                res_status_next = ST_EMPTY;
              end else begin
                res_status_next = ST_OK;
                res_data_next   = 1'b1;
                count_next      = count - 1'b1;
                if (opcode == OP_POP_FRONT) begin
                  rd_pos_next = head;
                  head_next   = head_inc;
                end else begin
                  rd_pos_next = back_last;
                end
              end
            end
            OP_SEARCH, OP_LIST: begin
              res_status_next = empty ? ST_EMPTY : ST_OK;
              rd_pos_next     = head;
              rem_next        = count;
              hit_next        = 1'b0;
              key_next        = value;
            end
            default: begin
              res_status_next = res_status;
            end
          endcase
        end
      end
      S_SCAN: begin
        // compare the word read last cycle and fetch the next one
        hit_next    = hit || (rdata == key);
        rd_pos_next = pos_inc;
        rem_next    = rem - 1'b1;
        if (rem == CNT_W'(1)) res_found_next = hit_next;
      end
      S_LIST: begin
        if (slot_free) begin
          rd_pos_next = pos_inc;
          rem_next    = rem - 1'b1;
        end
      end
      default: begin
        rd_pos_next = rd_pos;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      count  <= '0;
      rd_pos <= '0;
      rem    <= '0;
      hit    <= 1'b0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      count  <= count_next;
      rd_pos <= rd_pos_next;
      rem    <= rem_next;
      hit    <= hit_next;
    end
  end

  // pending reply and key
  always_ff @(posedge clk) begin
    key        <= key_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    res_data   <= res_data_next;
  end

  // response output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (slot_free && (state == S_REPLY || state == S_LIST)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // response word payload
  always_ff @(posedge clk) begin
    if (slot_free && state == S_REPLY) begin
      status  <= res_status;
      element <= res_data ? $signed(rdata) : '0;
      found   <= res_found;
      last    <= 1'b1;
    end else if (slot_free && state == S_LIST) begin
      status  <= ST_OK;
      element <= $signed(rdata);
      found   <= 1'b0;
      last    <= (rem == CNT_W'(1));
    end
  end

  // occupancy never exceeds the ring
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // head stays inside the ring
  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head <= IDX_W'(DEPTH - 1))
    else $error("head index outside ring");

  // walk states always have work left
  a_rem_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_LIST) |-> rem != '0)
    else $error("walk with nothing remaining");

  // queue contents only change when a request is taken
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> $stable(count) && $stable(head))
    else $error("queue changed during a walk");

  // a non-final word only comes from the list walk
  a_mid_list: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !last) |-> state == S_LIST)
    else $error("non-final word outside list walk");

endmodule

>>> tb/deque_with_search_top_tb.sv
// ----------------------------------------------------------------------------
// deque_with_search_top_tb
// Self-checking bench for the searchable double-ended queue. A small tracker
// class keeps its own ring, head and fill count. It works out the response
// words that every accepted request should give, and it checks each response
// word in order. Directed requests cover the empty, one-element and
// extreme-value cases. Random fill, drain and mixed phases follow, so the
// queue wraps and runs full. Both sides idle at random, and once the
// receiver holds off long enough to back up the request channel.
// ----------------------------------------------------------------------------
module deque_with_search_top_tb
  import dws_pkg::*;
();

  // opcodes the block takes and drops
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int HEAD_W          = $clog2(DEPTH_DEF);
  localparam int RANDOM_REQUESTS = 330;
  localparam int HOLDOFF_AT      = 60;
  localparam int HOLDOFF_CYCLES  = 300;
  localparam int LIMIT_CYCLES    = 1_000_000;

  localparam logic signed [DATA_W-1:0] MAX_WORD = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] MIN_WORD = 32'sh8000_0000;

  typedef struct {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] element;
    logic                     found;
    logic                     last;
  } dws_word_t;

  // tracker: own copy of the ring plus the words still owed by the block
  class deque_tracker;
    logic signed [DATA_W-1:0]   ring_words [DEPTH_DEF];
    logic [$clog2(DEPTH_DEF)-1:0] head_pos;
    logic [$clog2(DEPTH_DEF):0]   fill_count;
    dws_word_t                  owed_words [$];
    int mismatches;
    int full_rejects, empty_replies, searches, search_hits, list_words, peak_fill;

    function new();
      head_pos   = '0;
      fill_count = '0;
      mismatches = 0;
      full_rejects = 0;
      empty_replies = 0;
      searches = 0;
      search_hits = 0;
      list_words = 0;
      peak_fill = 0;
    endfunction

    function int ring_slot(int offset);
      return (int'(head_pos) + offset) % DEPTH_DEF;
    endfunction

    function int occupancy();
      return int'(fill_count);
    endfunction

    function int pending();
      return owed_words.size();
    endfunction

    function logic signed [DATA_W-1:0] held_word(int offset);
      return ring_words[ring_slot(offset)];
    endfunction

    function void owe(logic [STAT_W-1:0] st, logic signed [DATA_W-1:0] el,
                      logic fd, logic lt);
      dws_word_t w;
      w.status  = st;
      w.element = el;
      w.found   = fd;
      w.last    = lt;
      owed_words.push_back(w);
    endfunction

    // update the ring for one accepted request and queue its response words
    function void note_request(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val);
      logic signed [DATA_W-1:0] taken;
      logic hit;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (fill_count == DEPTH_DEF) begin
            full_rejects++;
            owe(ST_FULL, '0, 1'b0, 1'b1);
          end else begin
            if (op == OP_PUSH_FRONT) begin
              head_pos = (head_pos == '0) ? HEAD_W'(DEPTH_DEF - 1) : head_pos - 1'b1;
              ring_words[head_pos] = val;
            end else begin
              ring_words[ring_slot(int'(fill_count))] = val;
            end
            fill_count++;
            if (int'(fill_count) > peak_fill) peak_fill = int'(fill_count);
            owe(ST_OK, '0, 1'b0, 1'b1);
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (fill_count == 0) begin
            empty_replies++;
            owe(ST_EMPTY, '0, 1'b0, 1'b1);
          end else begin
            if (op == OP_POP_FRONT) begin
              taken = ring_words[head_pos];
              head_pos = (head_pos == HEAD_W'(DEPTH_DEF - 1)) ? '0 : head_pos + 1'b1;
            end else begin
              taken = ring_words[ring_slot(int'(fill_count) - 1)];
            end
            fill_count--;
            owe(ST_OK, taken, 1'b0, 1'b1);
          end
        end
        OP_SEARCH: begin
          if (fill_count == 0) begin
            empty_replies++;
            owe(ST_EMPTY, '0, 1'b0, 1'b1);
          end else begin
            hit = 1'b0;
            for (int i = 0; i < int'(fill_count); i++)
              if (ring_words[ring_slot(i)] == val) hit = 1'b1;
            searches++;
            if (hit) search_hits++;
            owe(ST_OK, '0, hit, 1'b1);
          end
        end
        OP_LIST: begin
          if (fill_count == 0) begin
            empty_replies++;
            owe(ST_EMPTY, '0, 1'b0, 1'b1);
          end else begin
            for (int i = 0; i < int'(fill_count); i++) begin
              owe(ST_OK, ring_words[ring_slot(i)], 1'b0, i == int'(fill_count) - 1);
              list_words++;
            end
          end
        end
        default: ;  // spare opcodes give nothing
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 50) $display("mismatch: %s", msg);
    endtask

    // compare one response word with the oldest owed word
    task check_response(logic [STAT_W-1:0] st, logic signed [DATA_W-1:0] el,
                        logic fd, logic lt);
      dws_word_t want;
      if (owed_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word status=%0d element=%0d", st, el));
        return;
      end
      want = owed_words.pop_front();
      if (st !== want.status)
        report_mismatch($sformatf("status %0d, wanted %0d", st, want.status));
      if (el !== want.element)
        report_mismatch($sformatf("element %0d, wanted %0d", el, want.element));
      if (fd !== want.found)
        report_mismatch($sformatf("found %b, wanted %b", fd, want.found));
      if (lt !== want.last)
        report_mismatch($sformatf("last %b, wanted %b", lt, want.last));
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_ready;
  logic [OP_W-1:0]          opcode = OP_PUSH_FRONT;
  logic signed [DATA_W-1:0] value = '0;
  logic                     rsp_valid;
  logic                     rsp_ready = 1'b0;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] element;
  logic                     found;
  logic                     last;

  deque_tracker tracker = new();
  int sender_quiet = 0;
  int receiver_quiet = 0;
  int words_seen = 0;
  int requests_sent = 0;
  int spare_sent = 0;

  deque_with_search_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .opcode    (opcode),
    .value     (value),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .element   (element),
    .found     (found),
    .last      (last)
  );

  always #10 clk = ~clk;

  // idle cycles before the next word, with runs of no idling
  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic logic signed [DATA_W-1:0] random_word();
    case ($urandom_range(0, 7))
      0: return MAX_WORD;
      1: return MIN_WORD;
      2: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      3: return $signed($urandom_range(0, 20)) - 32'sd10;
      default: return $signed($urandom());
    endcase
  endfunction

  // phase 0 fills, phase 1 drains, phase 2 mixes evenly
  function automatic logic [OP_W-1:0] pick_op(int phase);
    int r;
    logic [OP_W-1:0] push_op, pop_op;
    r = $urandom_range(0, 99);
    push_op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    pop_op  = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    if (phase == 2) begin
      case ($urandom_range(0, 5))
        0: return OP_PUSH_FRONT;
        1: return OP_PUSH_BACK;
        2: return OP_POP_FRONT;
        3: return OP_POP_BACK;
        4: return OP_SEARCH;
        default: return OP_LIST;
      endcase
    end
    if (r < 75) return (phase == 0) ? push_op : pop_op;
    if (r < 85) return OP_SEARCH;
    if (r < 90) return OP_LIST;
    return (phase == 0) ? pop_op : push_op;
  endfunction

  // offer one request word and hold it until accepted
  task automatic send_request(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val);
    int gap;
    gap = draw_wait(sender_quiet);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    opcode    <= op;
    value     <= val;
    do @(posedge clk); while (!req_ready);
    tracker.note_request(op, val);
    if (op == OP_SPARE_6 || op == OP_SPARE_7) spare_sent++;
    else requests_sent++;
  endtask

  // response side: random stalls, one long hold-off
  initial begin
    int stall;
    @(posedge clk iff !rst);
    forever begin
      stall = draw_wait(receiver_quiet);
      if (words_seen == HOLDOFF_AT) stall = HOLDOFF_CYCLES;
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      tracker.check_response(status, element, found, last);
      words_seen++;
    end
  end

  // request side: directed cases, then random phases
  initial begin
    logic [OP_W-1:0] dir_ops [21] = '{
      OP_LIST, OP_SEARCH, OP_POP_FRONT, OP_POP_BACK,
      OP_PUSH_BACK, OP_POP_BACK, OP_PUSH_BACK, OP_POP_FRONT,
      OP_PUSH_FRONT, OP_PUSH_FRONT, OP_PUSH_BACK, OP_LIST,
      OP_SEARCH, OP_SEARCH, OP_SEARCH, OP_SPARE_6, OP_SPARE_7,
      OP_POP_BACK, OP_POP_FRONT, OP_POP_FRONT, OP_LIST
    };
    logic signed [DATA_W-1:0] dir_vals [21] = '{
      32'sd0, 32'sd0, 32'sd0, 32'sd0,
      MAX_WORD, 32'sd0, MIN_WORD, 32'sd0,
      32'sd0, -32'sd1, 32'sh5555_aaaa, 32'sd0,
      -32'sd1, 32'sd5, 32'sh5555_aaaa, 32'sh2aaa_5555, 32'sd9,
      32'sd0, 32'sd0, 32'sd0, 32'sd0
    };
    int seg, seg_len, phase;
    logic [OP_W-1:0] op;
    logic signed [DATA_W-1:0] val;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty replies, one-element pops, extremes, search hit and miss
    for (int i = 0; i < 21; i++) send_request(dir_ops[i], dir_vals[i]);

    // random phases, so the ring wraps and runs full
    seg = 0;
    while (requests_sent < 21 - 2 + RANDOM_REQUESTS) begin
      phase   = seg % 3;
      seg_len = $urandom_range(24, 40);
      for (int j = 0; j < seg_len; j++) begin
        if ($urandom_range(0, 32) == 0) begin
          send_request($urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6, random_word());
        end else begin
          op = pick_op(phase);
          if (op == OP_SEARCH && tracker.occupancy() > 0 && $urandom_range(0, 1))
            val = tracker.held_word($urandom_range(0, tracker.occupancy() - 1));
          else
            val = random_word();
          send_request(op, val);
        end
      end
      seg++;
    end
    req_valid <= 1'b0;

    // drain owed words, then allow the block time for a stray word
    while (tracker.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d requests and %0d spare opcodes, %0d response words, peak fill %0d",
             requests_sent, spare_sent, words_seen, tracker.peak_fill);
    $display("full rejects %0d, empty replies %0d, search hits %0d of %0d, list words %0d",
             tracker.full_rejects, tracker.empty_replies, tracker.search_hits,
             tracker.searches, tracker.list_words);
    if (tracker.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles", LIMIT_CYCLES);
    $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
design/dws_pkg.sv
design/dws_ram.sv
design/deque_with_search_top.sv
tb/deque_with_search_top_tb.sv
